[rtl/core/flcd_pkg.sv]
`default_nettype none

package flcd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam logic [10:0] LINE_WIDTH_RESET = 11'd320;

   typedef enum logic [1:0] {
      KIND_WORD   = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_FINISH = 2'd2,
      KIND_STOP   = 2'd3
   } flcd_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_start;
   } flcd_req_type;

   typedef struct packed {
      flcd_kind_type kind;
      logic [19:0]   address;
      logic [15:0]   value;
      logic [7:0]    repeat_count;
      logic          rect_valid;
      logic [15:0]   rect_x;
      logic [15:0]   rect_y;
      logic [15:0]   rect_w;
      logic [15:0]   rect_h;
      logic          last;
   } flcd_rsp_type;

   typedef struct packed {
      logic first;
      logic second;
   } flcd_push_type;

endpackage

`default_nettype wire

[rtl/core/flc_delta_chunk_decoder.sv]
// Delta chunk decoder: takes the payload of one word-oriented line delta chunk,
// one byte per req word, and gives frame-buffer write commands on rsp.
// req: data_byte plus chunk_start, which restarts the parser on that byte.
// rsp: word runs (address, value, repeat count), last-pixel byte writes,
// a finish word with the dirty rectangle, or a stop word on a zero count.
// Each byte gives zero, one or two rsp words; last marks the final one.
// csr: write-only line width, saturated to MAX_WIDTH; always ready. Write it
// only while the decoder is idle; the block itself does not enforce this.
// Path: an accepted byte is held in the input register, and the words it gives
// are written into a two-entry result register that drives rsp.
// Throughput: one byte per cycle while req_stall is low; rsp moves one word
// per cycle unless rsp_stall is high, so a two-word byte can stall req.
// Reset: line width 320, parser waits for a line count, rsp empty.
// rsp_stall: held words stay put; req_stall rises once the result register
// cannot hold what the waiting byte gives.
`default_nettype none

module flc_delta_chunk_decoder import flcd_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire flcd_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output flcd_rsp_type     rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_data
);

   localparam logic [12:0] WIDTH_LIMIT = 13'(MAX_WIDTH);

   logic          in_valid_ff, in_valid_in;
   flcd_req_type  in_word_ff, in_word_in;
   logic [10:0]   width_ff, width_in;
   logic          take;
   flcd_push_type push;
   flcd_rsp_type  first_word;
   flcd_rsp_type  second_word;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      if (csr_valid && csr_ready) begin
         if (13'(csr_data) > WIDTH_LIMIT) begin
            width_in = 11'(WIDTH_LIMIT);
         end else begin
            width_in = csr_data;
         end
      end
   end

   assign req_stall   = in_valid_ff & ~take;
   assign in_valid_in = req_stall ? 1'b1 : req_valid;
   assign in_word_in  = req_stall ? in_word_ff : req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         width_ff    <= LINE_WIDTH_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         width_ff    <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   flcd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .line_width  (width_ff),
      .in_word     (in_word_ff),
      .take        (take),
      .push        (push),
      .first_word  (first_word),
      .second_word (second_word)
   );

   flcd_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .offer_valid (in_valid_ff),
      .push        (push),
      .first_word  (first_word),
      .second_word (second_word),
      .rsp_stall   (rsp_stall),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_FINISH || rsp_data.kind == KIND_STOP)
      |-> rsp_data.last)
      else $error("finish or stop word not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_WORD) |-> (rsp_data.repeat_count != 8'd0))
      else $error("word run with zero repeat count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("non-final word not followed by another");

endmodule

`default_nettype wire

[rtl/core/flcd_parser.sv]
`default_nettype none

module flcd_parser import flcd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [10:0]  line_width,
   input  wire flcd_req_type in_word,
   input  wire logic         take,
   output flcd_push_type     push,
   output flcd_rsp_type      first_word,
   output flcd_rsp_type      second_word
);

   typedef enum logic [3:0] {
      PH_LC_LO, PH_LC_HI, PH_OP_LO, PH_OP_HI, PH_SKIP, PH_COUNT,
      PH_LIT_LO, PH_LIT_HI, PH_REP_LO, PH_REP_HI, PH_DONE
   } phase_type;

   localparam logic [1:0] OP_PACKETS    = 2'd0;
   localparam logic [1:0] OP_LAST_PIXEL = 2'd2;
   localparam logic [1:0] OP_LINE_SKIP  = 2'd3;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [15:0] lines_ff, lines_in, cur_lines;
   logic [15:0] line_ff, line_in, cur_line;
   logic [13:0] packets_ff, packets_in, cur_packets;
   logic [15:0] column_ff, column_in, cur_column;
   logic [7:0]  low_ff, low_in, cur_low;
   logic [7:0]  run_ff, run_in, cur_run;
   logic [15:0] min_col_ff, min_col_in, cur_min_col;
   logic [15:0] min_line_ff, min_line_in, cur_min_line;
   logic [15:0] max_col_ff, max_col_in, cur_max_col;
   logic [15:0] max_line_ff, max_line_in, cur_max_line;
   logic        touched_ff, touched_in, cur_touched;

   logic [7:0]   b;
   logic [15:0]  op;
   logic [26:0]  line_prod;
   logic [19:0]  word_addr;
   logic [19:0]  pixel_addr;
   logic         end_pkt;
   logic         end_ln;
   logic         finish;
   logic         emit;
   flcd_rsp_type word_res;
   flcd_rsp_type fin_res;

   assign b  = in_word.data_byte;
   assign op = {b, cur_low};

   always_comb begin
      if (in_word.chunk_start) begin
         cur_phase    = PH_LC_LO;
         cur_lines    = '0;
         cur_line     = '0;
         cur_packets  = '0;
         cur_column   = '0;
         cur_low      = '0;
         cur_run      = '0;
         cur_min_col  = '1;
         cur_min_line = '1;
         cur_max_col  = '0;
         cur_max_line = '0;
         cur_touched  = 1'b0;
      end else begin
         cur_phase    = phase_ff;
         cur_lines    = lines_ff;
         cur_line     = line_ff;
         cur_packets  = packets_ff;
         cur_column   = column_ff;
         cur_low      = low_ff;
         cur_run      = run_ff;
         cur_min_col  = min_col_ff;
         cur_min_line = min_line_ff;
         cur_max_col  = max_col_ff;
         cur_max_line = max_line_ff;
         cur_touched  = touched_ff;
      end
   end

   assign line_prod  = 27'(cur_line) * 27'(line_width);
   assign word_addr  = 20'(line_prod + 27'(cur_column));
   assign pixel_addr = 20'(line_prod + 27'(line_width) - 27'd1);

   always_comb begin
      phase_in    = cur_phase;
      lines_in    = cur_lines;
      line_in     = cur_line;
      packets_in  = cur_packets;
      column_in   = cur_column;
      low_in      = cur_low;
      run_in      = cur_run;
      min_col_in  = cur_min_col;
      min_line_in = cur_min_line;
      max_col_in  = cur_max_col;
      max_line_in = cur_max_line;
      touched_in  = cur_touched;
      end_pkt     = 1'b0;
      end_ln      = 1'b0;
      finish      = 1'b0;
      emit        = 1'b0;
      word_res    = '0;
      fin_res     = '0;

      case (cur_phase)
         PH_LC_LO: begin
            low_in   = b;
            phase_in = PH_LC_HI;
         end
         PH_LC_HI: begin
            lines_in = op;
            if (op == 16'd0) begin
               finish = 1'b1;
            end else begin
               phase_in = PH_OP_LO;
            end
         end
         PH_OP_LO: begin
            low_in   = b;
            phase_in = PH_OP_HI;
         end
         PH_OP_HI: begin
            phase_in = PH_OP_LO;
            case (op[15:14])
               OP_PACKETS: begin
                  packets_in = op[13:0];
                  column_in  = '0;
                  if (op[13:0] == 14'd0) begin
                     end_ln = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               OP_LAST_PIXEL: begin
                  emit                  = 1'b1;
                  word_res.kind         = KIND_BYTE;
                  word_res.address      = pixel_addr;
                  word_res.value        = {8'd0, cur_low};
                  word_res.repeat_count = 8'd1;
               end
               OP_LINE_SKIP: begin
                  line_in = cur_line - op;
               end
               default: begin
               end
            endcase
         end
         PH_SKIP: begin
            column_in = cur_column + 16'(b);
            phase_in  = PH_COUNT;
         end
         PH_COUNT: begin
            if (b == 8'd0) begin
               emit          = 1'b1;
               word_res.kind = KIND_STOP;
               phase_in      = PH_DONE;
            end else begin
               touched_in = 1'b1;
               if (cur_column < cur_min_col) begin
                  min_col_in = cur_column;
               end
               if (cur_line < cur_min_line) begin
                  min_line_in = cur_line;
               end
               if (cur_line > cur_max_line) begin
                  max_line_in = cur_line;
               end
               if (b[7]) begin
                  run_in   = 8'd0 - b;
                  phase_in = PH_REP_LO;
               end else begin
                  run_in   = b;
                  phase_in = PH_LIT_LO;
               end
            end
         end
         PH_LIT_LO: begin
            low_in   = b;
            phase_in = PH_LIT_HI;
         end
         PH_LIT_HI: begin
            emit                  = 1'b1;
            word_res.kind         = KIND_WORD;
            word_res.address      = word_addr;
            word_res.value        = op;
            word_res.repeat_count = 8'd1;
            column_in             = cur_column + 16'd2;
            run_in                = cur_run - 8'd1;
            if (run_in == 8'd0) begin
               end_pkt = 1'b1;
            end else begin
               phase_in = PH_LIT_LO;
            end
         end
         PH_REP_LO: begin
            low_in   = b;
            phase_in = PH_REP_HI;
         end
         PH_REP_HI: begin
            emit                  = 1'b1;
            word_res.kind         = KIND_WORD;
            word_res.address      = word_addr;
            word_res.value        = op;
            word_res.repeat_count = cur_run;
            column_in             = cur_column + {7'd0, cur_run, 1'b0};
            end_pkt               = 1'b1;
         end
         default: begin
         end
      endcase

      if (end_pkt) begin
         if (column_in > cur_max_col) begin
            max_col_in = column_in;
         end
         packets_in = cur_packets - 14'd1;
         if (packets_in == 14'd0) begin
            end_ln = 1'b1;
         end else begin
            phase_in = PH_SKIP;
         end
      end

      if (end_ln) begin
         line_in  = line_in + 16'd1;
         lines_in = cur_lines - 16'd1;
         if (lines_in == 16'd0) begin
            finish = 1'b1;
         end else begin
            phase_in = PH_OP_LO;
         end
      end

      if (finish) begin
         phase_in     = PH_DONE;
         fin_res.kind = KIND_FINISH;
         fin_res.last = 1'b1;
         if (touched_in) begin
            fin_res.rect_valid = 1'b1;
            fin_res.rect_x     = min_col_in;
            fin_res.rect_y     = min_line_in;
            fin_res.rect_w     = max_col_in - min_col_in + 16'd1;
            fin_res.rect_h     = max_line_in - min_line_in + 16'd1;
         end
      end
   end

   always_comb begin
      push.first    = emit | finish;
      push.second   = emit & finish;
      second_word   = fin_res;
      if (emit) begin
         first_word      = word_res;
         first_word.last = ~finish;
      end else begin
         first_word = fin_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LC_LO;
         lines_ff    <= '0;
         line_ff     <= '0;
         packets_ff  <= '0;
         column_ff   <= '0;
         low_ff      <= '0;
         run_ff      <= '0;
         min_col_ff  <= '1;
         min_line_ff <= '1;
         max_col_ff  <= '0;
         max_line_ff <= '0;
         touched_ff  <= 1'b0;
      end else if (take) begin
         phase_ff    <= phase_in;
         lines_ff    <= lines_in;
         line_ff     <= line_in;
         packets_ff  <= packets_in;
         column_ff   <= column_in;
         low_ff      <= low_in;
         run_ff      <= run_in;
         min_col_ff  <= min_col_in;
         min_line_ff <= min_line_in;
         max_col_ff  <= max_col_in;
         max_line_ff <= max_line_in;
         touched_ff  <= touched_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/flcd_rsp_buf.sv]
`default_nettype none

module flcd_rsp_buf import flcd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    offer_valid,
   input  wire flcd_push_type push,
   input  wire flcd_rsp_type first_word,
   input  wire flcd_rsp_type second_word,
   input  wire logic    rsp_stall,
   output logic         take,
   output logic         rsp_valid,
   output flcd_rsp_type rsp_data
);

   logic [1:0]   cnt_ff, cnt_in;
   logic [1:0]   kept;
   logic [1:0]   pushed;
   logic         pop;
   flcd_rsp_type slot0_ff, slot0_in;
   flcd_rsp_type slot1_ff, slot1_in;

   assign pop    = (cnt_ff != 2'd0) && !rsp_stall;
   assign kept   = cnt_ff - {1'b0, pop};
   assign pushed = push.second ? 2'd2 : {1'b0, push.first};
   assign take   = offer_valid && (({1'b0, kept} + {1'b0, pushed}) <= 3'd2);

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = kept;
      if (take) begin
         cnt_in = kept + pushed;
         case (kept)
            2'd0: begin
               slot0_in = first_word;
               slot1_in = second_word;
            end
            2'd1: begin
               slot1_in = first_word;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;

endmodule

`default_nettype wire
